FILE: rtl/omni_wheel_inverse_kinematics_top_assert.svh
// Assertion macros for the omni wheel inverse kinematics block.
// Used by the top level; expects signals clk and rst in scope.
`ifndef OMNI_WHEEL_INVERSE_KINEMATICS_TOP_ASSERT_SVH
`define OMNI_WHEEL_INVERSE_KINEMATICS_TOP_ASSERT_SVH

// same-cycle implication
`define OWIK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OWIK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/owik_pkg.sv
// Shared constants and types for the omni wheel inverse kinematics block.
// No dependencies.
`timescale 1ns / 1ps
package owik_pkg;

  // default parameter values
  localparam int unsigned ANGLE_BITS_DEF     = 16;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 15;

  // field widths
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned RADIUS_W = 16;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned WHEELS   = 4;

  // configuration registers
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [0:0] REG_LIMIT  = 1'b1;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd2000;

  // arithmetic constants
  localparam logic [31:0] PI_Q30        = 32'd3373259426;
  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
  localparam logic [19:0] INV_SQRT2_Q20 = 20'd741455;

  // pipeline shape
  localparam int unsigned N_CELLS  = 5;
  localparam int unsigned TRIG_LAT = 2 + 3 * N_CELLS + 1;
  localparam int unsigned MIX_LAT  = 5;
  localparam int unsigned DEPTH    = TRIG_LAT + MIX_LAT;

  // data handed from one series cell to the next
  typedef struct packed {
    logic [29:0] x2;
    logic [30:0] st;
    logic [30:0] ct;
    logic [31:0] sacc;
    logic [31:0] cacc;
    logic [2:0]  oct;
  } trig_bus_t;

endpackage

FILE: rtl/owik_if.sv
// Stream interfaces for command and wheel speed beats.
// Depends on owik_pkg.
`timescale 1ns / 1ps
interface owik_cmd_if;
  logic valid;
  logic ready;
  logic signed [owik_pkg::SPEED_W-1:0] move_speed;
  logic [owik_pkg::ANGLE_W-1:0]        move_direction;
  logic signed [owik_pkg::RATE_W-1:0]  turn_rate;
  logic [owik_pkg::ANGLE_W-1:0]        heading;
  modport source (output valid, move_speed, move_direction, turn_rate, heading, input ready);
  modport sink (input valid, move_speed, move_direction, turn_rate, heading, output ready);
endinterface

interface owik_res_if;
  logic valid;
  logic ready;
  logic signed [owik_pkg::SPEED_W-1:0] wheel_zero_speed;
  logic signed [owik_pkg::SPEED_W-1:0] wheel_one_speed;
  logic signed [owik_pkg::SPEED_W-1:0] wheel_two_speed;
  logic signed [owik_pkg::SPEED_W-1:0] wheel_three_speed;
  logic [owik_pkg::WHEELS-1:0]         clamp_flags;
  modport source (output valid, wheel_zero_speed, wheel_one_speed, wheel_two_speed,
                  wheel_three_speed, clamp_flags, input ready);
  modport sink (input valid, wheel_zero_speed, wheel_one_speed, wheel_two_speed,
                wheel_three_speed, clamp_flags, output ready);
endinterface

FILE: rtl/owik_trig_cell.sv
// One Taylor series cell: adds term K of cosine, and of sine for K up to 4, in three stages.
// Depends on owik_pkg.
`timescale 1ns / 1ps
module owik_trig_cell #(
  parameter int unsigned K = 1
) (
  input  logic                clk,
  input  logic                en,
  input  owik_pkg::trig_bus_t bi,
  output owik_pkg::trig_bus_t bo
);
  localparam longint unsigned DS = (2 * K) * (2 * K + 1);
  localparam longint unsigned DC = (2 * K - 1) * (2 * K);
  localparam logic [29:0] MS = 30'((64'd1 << 30) / DS);
  localparam logic [29:0] MC = 30'((64'd1 << 30) / DC);
  localparam bit SIN_ON = (K <= 4);
  localparam bit SUB    = (K % 2 == 1);

  owik_pkg::trig_bus_t b1, b2;
  logic [29:0] ns1, nc1, ns2, nc2, qs2, qc2;
  logic [60:0] prod_s, prod_c;
  logic [59:0] rprod_s, rprod_c;
  logic [29:0] rs, rc, qs, qc;

  // stage 1: term times x squared
  assign prod_s = bi.st * 61'(bi.x2);
  assign prod_c = bi.ct * 61'(bi.x2);
  always_ff @(posedge clk) begin
    if (en) begin
      b1  <= bi;
      ns1 <= prod_s[59:30];
      nc1 <= prod_c[59:30];
    end
  end

  // stage 2: quotient estimate by reciprocal
  assign rprod_s = ns1 * 60'(MS);
  assign rprod_c = nc1 * 60'(MC);
  always_ff @(posedge clk) begin
    if (en) begin
      b2  <= b1;
      ns2 <= ns1;
      nc2 <= nc1;
      qs2 <= rprod_s[59:30];
      qc2 <= rprod_c[59:30];
    end
  end

  // stage 3: estimate is low by at most one
  assign rs = ns2 - 30'(qs2 * 30'(DS));
  assign rc = nc2 - 30'(qc2 * 30'(DC));
  assign qs = qs2 + 30'(rs >= 30'(DS));
  assign qc = qc2 + 30'(rc >= 30'(DC));
  always_ff @(posedge clk) begin
    if (en) begin
      bo.x2  <= b2.x2;
      bo.oct <= b2.oct;
      bo.ct  <= 31'(qc);
      bo.cacc <= SUB ? b2.cacc - 32'(qc) : b2.cacc + 32'(qc);
      if (SIN_ON) begin
        bo.st   <= 31'(qs);
        bo.sacc <= SUB ? b2.sacc - 32'(qs) : b2.sacc + 32'(qs);
      end else begin
        bo.st   <= b2.st;
        bo.sacc <= b2.sacc;
      end
    end
  end
endmodule

FILE: rtl/owik_trig.sv
// Sine and cosine of a binary angle: octant fold, radian scaling,
// a chain of Taylor cells and octant restore. Depends on owik_pkg, owik_trig_cell.
`timescale 1ns / 1ps
module owik_trig #(
  parameter int unsigned ANGLE_BITS     = owik_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = owik_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [owik_pkg::ANGLE_W-1:0]        ang,
  output logic signed [TRIG_FRAC_BITS+1:0]    sn,
  output logic signed [TRIG_FRAC_BITS+1:0]    cs
);
  localparam int unsigned AB = ANGLE_BITS;
  localparam int unsigned F  = TRIG_FRAC_BITS;
  localparam int unsigned AW = (AB > owik_pkg::ANGLE_W) ? AB : owik_pkg::ANGLE_W;
  localparam logic [AB-3:0] EIGHTH = (AB-2)'(1) << (AB - 3);
  localparam logic [AB+29:0] HALF = (AB+30)'(1) << (AB - 2);
  localparam logic [32:0] RND = 33'(1) << (29 - F);

  logic [AW-1:0]   ang_ext;
  logic [AB-1:0]   a;
  logic [AB-3:0]   p;
  logic [AB+29:0]  xprod;
  logic [29:0]     x1, x2s;
  logic [2:0]      oct1;
  logic [59:0]     sq;
  owik_pkg::trig_bus_t bus [0:owik_pkg::N_CELLS];
  owik_pkg::trig_bus_t b0;
  logic [32:0]     srnd, crnd;
  logic [F:0]      s, c;
  logic signed [F+1:0] sp, cp;

  // stage 1: fold into one octant and scale to radians in Q30
  assign ang_ext = AW'(ang);
  assign a = ang_ext[AB-1:0];
  assign p = a[AB-3] ? EIGHTH - (AB-2)'(a[AB-4:0]) : (AB-2)'(a[AB-4:0]);
  assign xprod = (AB+30)'(p) * (AB+30)'(owik_pkg::PI_Q30) + HALF;
  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= xprod[AB+28:AB-1];
      oct1 <= a[AB-1:AB-3];
    end
  end

  // stage 2: x squared, seed the series
  assign sq = x1 * x1;
  assign x2s = sq[59:30];
  always_ff @(posedge clk) begin
    if (en) begin
      b0.x2   <= x2s;
      b0.st   <= 31'(x1);
      b0.ct   <= owik_pkg::ONE_Q30;
      b0.sacc <= 32'(x1);
      b0.cacc <= 32'(owik_pkg::ONE_Q30);
      b0.oct  <= oct1;
    end
  end
  assign bus[0] = b0;

  // series cells
  for (genvar k = 1; k <= owik_pkg::N_CELLS; k++) begin : g_cell
    owik_trig_cell #(.K(k)) u_cell (
      .clk (clk),
      .en  (en),
      .bi  (bus[k-1]),
      .bo  (bus[k])
    );
  end

  // round to output scale and restore octant
  assign srnd = 33'(bus[owik_pkg::N_CELLS].sacc) + RND;
  assign crnd = 33'(bus[owik_pkg::N_CELLS].cacc) + RND;
  assign s  = srnd[30:30-F];
  assign c  = crnd[30:30-F];
  assign sp = (F+2)'(s);
  assign cp = (F+2)'(c);
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (bus[owik_pkg::N_CELLS].oct)
        3'd0: begin sn <= sp;  cs <= cp;  end
        3'd1: begin sn <= cp;  cs <= sp;  end
        3'd2: begin sn <= cp;  cs <= -sp; end
        3'd3: begin sn <= sp;  cs <= -cp; end
        3'd4: begin sn <= -sp; cs <= -cp; end
        3'd5: begin sn <= -cp; cs <= -sp; end
        3'd6: begin sn <= -cp; cs <= sp;  end
        default: begin sn <= -sp; cs <= cp; end
      endcase
    end
  end
endmodule

FILE: rtl/owik_mix.sv
// Wheel mixing: field rotation, turn term, divide by sqrt 2 and clamp.
// Five register stages; clamp is combinational after the last. Depends on owik_pkg.
`timescale 1ns / 1ps
module owik_mix #(
  parameter int unsigned TRIG_FRAC_BITS = owik_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [owik_pkg::SPEED_W-1:0]   spd,
  input  logic signed [owik_pkg::RATE_W-1:0]    omega,
  input  logic [owik_pkg::RADIUS_W-1:0]         radius,
  input  logic [owik_pkg::LIMIT_W-1:0]          limit,
  input  logic signed [TRIG_FRAC_BITS+1:0]      sd,
  input  logic signed [TRIG_FRAC_BITS+1:0]      cd,
  input  logic signed [TRIG_FRAC_BITS+1:0]      sh,
  input  logic signed [TRIG_FRAC_BITS+1:0]      ch,
  output logic [owik_pkg::WHEELS-1:0][owik_pkg::SPEED_W-1:0] speed,
  output logic [owik_pkg::WHEELS-1:0]           flags
);
  localparam int unsigned F  = TRIG_FRAC_BITS;
  localparam int unsigned TW = F + 2;
  localparam int unsigned VW = TW + owik_pkg::SPEED_W;
  localparam int unsigned CW = TW + 1;
  localparam int unsigned PW = CW + VW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned SH = 2 * F - 16;
  localparam int unsigned QW = SW - SH;
  localparam int unsigned MW = QW + 20 - 36;

  logic signed [VW-1:0] vx, vy;
  logic signed [CW-1:0] cps, cms;
  logic signed [32:0]   rot0;
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic signed [SW-1:0] rotw;
  logic signed [SW-1:0] sum [owik_pkg::WHEELS];
  logic [SW-1:0]        mag [owik_pkg::WHEELS];
  logic [QW-1:0]        q16 [owik_pkg::WHEELS];
  logic [owik_pkg::WHEELS-1:0] neg4, neg5;
  logic [QW+19:0]       sc  [owik_pkg::WHEELS];
  logic [MW-1:0]        mm  [owik_pkg::WHEELS];

  // M1: resolve velocity, wheel coefficients, turn term
  always_ff @(posedge clk) begin
    if (en) begin
      vx   <= VW'(spd) * VW'(cd);
      vy   <= VW'(spd) * VW'(sd);
      cps  <= CW'(ch) + CW'(sh);
      cms  <= CW'(ch) - CW'(sh);
      rot0 <= 33'($signed({1'b0, radius})) * 33'(omega);
    end
  end

  // M2: the four distinct products
  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= PW'(cps) * PW'(vx);
      p2   <= PW'(cms) * PW'(vy);
      p3   <= PW'(cms) * PW'(vx);
      p4   <= PW'(cps) * PW'(vy);
      rotw <= SW'(rot0) <<< SH;
    end
  end

  // M3: wheel sums
  always_ff @(posedge clk) begin
    if (en) begin
      sum[0] <= rotw - SW'(p1) + SW'(p2);
      sum[1] <= rotw - SW'(p3) - SW'(p4);
      sum[2] <= rotw + SW'(p1) - SW'(p2);
      sum[3] <= rotw + SW'(p3) + SW'(p4);
    end
  end

  // M4: magnitude, truncated to Q16
  always_comb begin
    for (int i = 0; i < owik_pkg::WHEELS; i++) begin
      mag[i] = sum[i][SW-1] ? SW'(-sum[i]) : SW'(sum[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < owik_pkg::WHEELS; i++) begin
        neg4[i] <= sum[i][SW-1];
        q16[i]  <= mag[i][SW-1:SH];
      end
    end
  end

  // M5: scale by 1/sqrt 2
  always_comb begin
    for (int i = 0; i < owik_pkg::WHEELS; i++) begin
      sc[i] = (QW+20)'(q16[i]) * (QW+20)'(owik_pkg::INV_SQRT2_Q20);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      neg5 <= neg4;
      for (int i = 0; i < owik_pkg::WHEELS; i++) begin
        mm[i] <= sc[i][QW+19:36];
      end
    end
  end

  // clamp and restore sign
  always_comb begin
    for (int i = 0; i < owik_pkg::WHEELS; i++) begin
      logic [owik_pkg::LIMIT_W-1:0] mc;
      flags[i] = mm[i] > MW'(limit);
      mc = flags[i] ? limit : mm[i][owik_pkg::LIMIT_W-1:0];
      speed[i] = neg5[i] ? -{1'b0, mc} : {1'b0, mc};
    end
  end
endmodule

FILE: rtl/omni_wheel_inverse_kinematics_top.sv
// Top level of the omni wheel inverse kinematics block: APB registers,
// pipeline control and output register. Depends on owik_pkg, owik_if, owik_trig, owik_mix.
`timescale 1ns / 1ps
`include "omni_wheel_inverse_kinematics_top_assert.svh"
// Fully pipelined: one command beat per clock unless stalled. A taken beat passes
// through the two sine/cosine units, whose five Taylor cells take three stages each,
// then wheel mixing, then the output register. The pipeline stalls only when its
// last stage holds a result and the output register is still full; otherwise
// commands keep flowing. Write registers only while idle.
module omni_wheel_inverse_kinematics_top #(
  parameter int unsigned ANGLE_BITS     = owik_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = owik_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  owik_cmd_if.sink                         cmd,
  owik_res_if.source                       res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [owik_pkg::PADDR_W-1:0]     paddr,
  input  logic [owik_pkg::PDATA_W-1:0]     pwdata,
  output logic [owik_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  localparam int unsigned TL = owik_pkg::TRIG_LAT;
  localparam int unsigned D  = owik_pkg::DEPTH;

  logic [owik_pkg::RADIUS_W-1:0] radius;
  logic [owik_pkg::LIMIT_W-1:0]  limit;
  logic [owik_pkg::LIMIT_W-1:0]  out_limit;
  logic [D-1:0]                  vld;
  logic                          en, take;
  logic signed [owik_pkg::SPEED_W-1:0] spd_line [TL];
  logic signed [owik_pkg::RATE_W-1:0]  omg_line [TL];
  logic signed [TRIG_FRAC_BITS+1:0]    sd, cd, sh, ch;
  logic [owik_pkg::WHEELS-1:0][owik_pkg::SPEED_W-1:0] speed;
  logic [owik_pkg::WHEELS-1:0]   flags;
  logic                          res_valid_next;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= owik_pkg::RADIUS_RESET;
      limit  <= owik_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        owik_pkg::REG_RADIUS: radius <= pwdata[owik_pkg::RADIUS_W-1:0];
        owik_pkg::REG_LIMIT:  limit  <= pwdata[owik_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[2])
      owik_pkg::REG_RADIUS: prdata = owik_pkg::PDATA_W'(radius);
      owik_pkg::REG_LIMIT:  prdata = owik_pkg::PDATA_W'(limit);
      default:              prdata = '0;
    endcase
  end

  // pipeline advance
  assign en = !(vld[D-1] && res.valid && !res.ready);
  assign cmd.ready = en;
  assign take = cmd.valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], take};
    end
  end

  // side line carrying speed and turn rate past the trig units
  always_ff @(posedge clk) begin
    if (en) begin
      spd_line[0] <= cmd.move_speed;
      omg_line[0] <= cmd.turn_rate;
      for (int i = 1; i < TL; i++) begin
        spd_line[i] <= spd_line[i-1];
        omg_line[i] <= omg_line[i-1];
      end
    end
  end

  owik_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_dir (
    .clk (clk), .en (en), .ang (cmd.move_direction), .sn (sd), .cs (cd)
  );
  owik_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_head (
    .clk (clk), .en (en), .ang (cmd.heading), .sn (sh), .cs (ch)
  );

  owik_mix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_mix (
    .clk    (clk),
    .en     (en),
    .spd    (spd_line[TL-1]),
    .omega  (omg_line[TL-1]),
    .radius (radius),
    .limit  (limit),
    .sd     (sd),
    .cd     (cd),
    .sh     (sh),
    .ch     (ch),
    .speed  (speed),
    .flags  (flags)
  );

  // output register
  always_comb begin
    priority if (vld[D-1] && en) res_valid_next = 1'b1;
    else if (res.ready)          res_valid_next = 1'b0;
    else                         res_valid_next = res.valid;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= res_valid_next;
    end
  end
  always_ff @(posedge clk) begin
    if (vld[D-1] && en) begin
      res.wheel_zero_speed  <= speed[0];
      res.wheel_one_speed   <= speed[1];
      res.wheel_two_speed   <= speed[2];
      res.wheel_three_speed <= speed[3];
      res.clamp_flags       <= flags;
      out_limit             <= limit;
    end
  end

  // checks
  `OWIK_ASSERT_NXT(a_take_enters, take, vld[0], "accepted beat did not enter the pipeline")
  `OWIK_ASSERT_NXT(a_last_holds, (vld[D-1] && !en), vld[D-1], "stalled result was dropped")
  `OWIK_ASSERT_IMP(a_flag0_at_limit, (res.valid && res.clamp_flags[0]),
    ($signed(res.wheel_zero_speed) == $signed({1'b0, out_limit}) ||
     $signed(res.wheel_zero_speed) == -$signed({1'b0, out_limit})),
    "wheel zero flagged but not at limit")
  `OWIK_ASSERT_IMP(a_w3_in_range, res.valid,
    ($signed(res.wheel_three_speed) <= $signed({1'b0, out_limit}) &&
     $signed(res.wheel_three_speed) >= -$signed({1'b0, out_limit})),
    "wheel three speed beyond limit")
endmodule
